// ----- hw/rtl/cma_pkg.sv -----
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the centered moving average unit.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int HALF_WIDTH_BITS = 6;
    localparam logic [HALF_WIDTH_BITS-1:0] HALF_WIDTH_RESET = 6'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INJECT,
        ST_DRAIN
    } t_state;

    // control part of a summing token travelling down the cell chain
    typedef struct packed {
        logic valid;
        logic fin;
    } t_tok_ctl;

endpackage

// ----- hw/rtl/centered_moving_average_unit.sv -----
// ----------------------------------------------------------------------------
// centered_moving_average_unit
// Centered boxcar moving average over a sample series, built as a chain of
// sample cells that a summing token walks through, followed by a divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries i_sample and i_final_sample; a
//   transfer happens when both are high. Output channel (o_valid/i_ready)
//   carries o_average and o_final_result. i_cfg_we writes i_cfg_data as the
//   half width N; the user must write it only while the block is idle, as
//   the block itself does not enforce this. One sample is taken at a time.
//   Each sample shifts into the cell chain, then one token per result walks
//   the 2*MAX_HALF_WIDTH cells, one per cycle unless the divider stalls
//   the chain, collecting the window sum; the divider then works out the
//   quotient. The final sample flushes up to N results, which the divider
//   takes one after another. The output register holds a result while the
//   receiver stalls; the chain and divider stop behind it, and no new sample
//   is taken until all results of the current one have left the chain.
//   Reset clears control state, the series position and sets N to 15.
// ----------------------------------------------------------------------------
module centered_moving_average_unit #(
    parameter int MAX_HALF_WIDTH = 32,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cma_pkg::HALF_WIDTH_BITS-1:0]  i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic                                 i_final_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [SAMPLE_BITS-1:0]               o_average,
    output logic                                 o_final_result
);

    localparam int DEPTH    = 2 * MAX_HALF_WIDTH;
    localparam int CNT_BITS = $clog2(DEPTH) + 1;
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(DEPTH);
    localparam int K_BITS   = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
    localparam int OUT_BITS = $clog2(MAX_HALF_WIDTH + 1) + 1;

    logic [cma_pkg::HALF_WIDTH_BITS-1:0] r_half_width;
    cma_pkg::t_state                     r_state;
    cma_pkg::t_state                     n_state;
    logic [CNT_BITS-1:0]                 r_seen;
    logic [CNT_BITS-1:0]                 n_seen;
    logic                                r_last;
    logic                                n_last;
    logic [K_BITS-1:0]                   r_k;
    logic [K_BITS-1:0]                   n_k;
    logic [OUT_BITS-1:0]                 r_outstanding;

    logic [CNT_BITS-1:0]    w_n;
    logic [CNT_BITS:0]      w_two_n;
    logic [CNT_BITS:0]      w_nk1;
    logic                   w_shift;
    logic                   w_adv;
    logic                   w_take;
    cma_pkg::t_tok_ctl      w_inj_ctl;
    logic [CNT_BITS-1:0]    w_inj_cnt;

    logic [SAMPLE_BITS-1:0] w_sample [DEPTH];
    cma_pkg::t_tok_ctl      w_ctl    [DEPTH];
    logic [SUM_BITS-1:0]    w_sum    [DEPTH];
    logic [CNT_BITS-1:0]    w_cnt    [DEPTH];

    logic                   w_div_ready;

    // effective half width
    always_comb begin
        if (r_half_width == '0) begin
            w_n = CNT_BITS'(1);
        end else if (32'(r_half_width) > MAX_HALF_WIDTH) begin
            w_n = CNT_BITS'(MAX_HALF_WIDTH);
        end else begin
            w_n = CNT_BITS'(r_half_width);
        end
    end

    assign w_two_n = {w_n, 1'b0};
    assign w_nk1   = {1'b0, w_n} + (CNT_BITS + 1)'(r_k) + (CNT_BITS + 1)'(1);

    assign w_take = w_ctl[DEPTH-1].valid && w_div_ready;
    assign w_adv  = !(w_ctl[DEPTH-1].valid && !w_div_ready);

    // cell chain
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        if (j == 0) begin : g_head
            cma_cell #(
                .CELL_INDEX  (j),
                .SAMPLE_BITS (SAMPLE_BITS),
                .SUM_BITS    (SUM_BITS),
                .CNT_BITS    (CNT_BITS)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_shift),
                .i_adv    (w_adv),
                .i_sample (i_sample),
                .o_sample (w_sample[j]),
                .i_ctl    (w_inj_ctl),
                .i_sum    ('0),
                .i_cnt    (w_inj_cnt),
                .o_ctl    (w_ctl[j]),
                .o_sum    (w_sum[j]),
                .o_cnt    (w_cnt[j])
            );
        end else begin : g_body
            cma_cell #(
                .CELL_INDEX  (j),
                .SAMPLE_BITS (SAMPLE_BITS),
                .SUM_BITS    (SUM_BITS),
                .CNT_BITS    (CNT_BITS)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_shift),
                .i_adv    (w_adv),
                .i_sample (w_sample[j-1]),
                .o_sample (w_sample[j]),
                .i_ctl    (w_ctl[j-1]),
                .i_sum    (w_sum[j-1]),
                .i_cnt    (w_cnt[j-1]),
                .o_ctl    (w_ctl[j]),
                .o_sum    (w_sum[j]),
                .o_cnt    (w_cnt[j])
            );
        end
    end

    cma_div #(
        .SUM_BITS (SUM_BITS),
        .CNT_BITS (CNT_BITS),
        .AVG_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_ctl[DEPTH-1].valid),
        .o_ready   (w_div_ready),
        .i_sum     (w_sum[DEPTH-1]),
        .i_cnt     (w_cnt[DEPTH-1]),
        .i_fin     (w_ctl[DEPTH-1].fin),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_average (o_average),
        .o_fin     (o_final_result)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_last    = r_last;
        n_k       = r_k;
        o_ready   = 1'b0;
        w_shift   = 1'b0;
        w_inj_ctl = '0;
        w_inj_cnt = '0;
        unique case (r_state)
            cma_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_shift = 1'b1;
                    n_seen  = (r_seen == CNT_BITS'(DEPTH)) ? r_seen
                                                           : r_seen + CNT_BITS'(1);
                    n_last  = i_final_sample;
                    n_k     = K_BITS'(w_n - CNT_BITS'(1));
                    n_state = cma_pkg::ST_INJECT;
                end
            end
            cma_pkg::ST_INJECT: begin
                if (!r_last) begin
                    if (r_seen < w_n) begin
                        n_state = cma_pkg::ST_DRAIN;
                    end else if (w_adv) begin
                        w_inj_ctl.valid = 1'b1;
                        w_inj_cnt = ({1'b0, r_seen} < w_two_n) ? r_seen
                                                               : w_two_n[CNT_BITS-1:0];
                        n_state = cma_pkg::ST_DRAIN;
                    end
                end else if (w_adv) begin
                    if (CNT_BITS'(r_k) < r_seen) begin
                        w_inj_ctl.valid = 1'b1;
                        w_inj_ctl.fin   = (r_k == '0);
                        w_inj_cnt = ({1'b0, r_seen} < w_nk1) ? r_seen
                                                             : w_nk1[CNT_BITS-1:0];
                    end
                    if (r_k == '0) begin
                        n_seen  = '0;
                        n_state = cma_pkg::ST_DRAIN;
                    end else begin
                        n_k = r_k - K_BITS'(1);
                    end
                end
            end
            cma_pkg::ST_DRAIN: begin
                if (r_outstanding == '0) begin
                    n_state = cma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cma_pkg::ST_IDLE;
            r_seen        <= '0;
            r_last        <= 1'b0;
            r_k           <= '0;
            r_outstanding <= '0;
            r_half_width  <= cma_pkg::HALF_WIDTH_RESET;
        end else begin
            r_state       <= n_state;
            r_seen        <= n_seen;
            r_last        <= n_last;
            r_k           <= n_k;
            r_outstanding <= r_outstanding + OUT_BITS'(w_inj_ctl.valid)
                                           - OUT_BITS'(w_take);
            if (i_cfg_we) begin
                r_half_width <= i_cfg_data;
            end
        end
    end

endmodule

// ----- hw/rtl/cma_cell.sv -----
// ----------------------------------------------------------------------------
// cma_cell
// One cell of the sample chain: holds one sample and adds it to a passing
// summing token when the token's count covers this cell.
// ----------------------------------------------------------------------------
module cma_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int SAMPLE_BITS = 24,
    parameter int SUM_BITS    = 30,
    parameter int CNT_BITS    = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic                  i_adv,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_sample,
    input  cma_pkg::t_tok_ctl     i_ctl,
    input  logic [SUM_BITS-1:0]   i_sum,
    input  logic [CNT_BITS-1:0]   i_cnt,
    output cma_pkg::t_tok_ctl     o_ctl,
    output logic [SUM_BITS-1:0]   o_sum,
    output logic [CNT_BITS-1:0]   o_cnt
);

    logic [SAMPLE_BITS-1:0] r_sample;
    cma_pkg::t_tok_ctl      r_ctl;
    logic [SUM_BITS-1:0]    r_sum;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [SUM_BITS-1:0]    n_sum;

    always_comb begin
        if (i_cnt > CNT_BITS'(CELL_INDEX)) begin
            n_sum = i_sum + SUM_BITS'(r_sample);
        end else begin
            n_sum = i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
        if (i_adv) begin
            r_sum <= n_sum;
            r_cnt <= i_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    assign o_sample = r_sample;
    assign o_ctl    = r_ctl;
    assign o_sum    = r_sum;
    assign o_cnt    = r_cnt;

endmodule

// ----- hw/rtl/cma_div.sv -----
// ----------------------------------------------------------------------------
// cma_div
// Restoring divider, one quotient bit per cycle, with the result register
// that drives the output channel.
// ----------------------------------------------------------------------------
module cma_div #(
    parameter int SUM_BITS = 30,
    parameter int CNT_BITS = 7,
    parameter int AVG_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SUM_BITS-1:0] i_sum,
    input  logic [CNT_BITS-1:0] i_cnt,
    input  logic                i_fin,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [AVG_BITS-1:0] o_average,
    output logic                o_fin
);

    localparam int STEP_BITS = $clog2(SUM_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_step;
    logic [CNT_BITS-1:0]  r_rem;
    logic [CNT_BITS-1:0]  r_div;
    logic [SUM_BITS-1:0]  r_quo;
    logic                 r_fin;
    logic                 r_out_valid;
    logic [AVG_BITS-1:0]  r_avg;
    logic                 r_out_fin;

    logic [CNT_BITS:0]    w_shift;
    logic [CNT_BITS:0]    w_diff;
    logic                 w_ge;
    logic                 w_load_out;

    assign w_shift    = {r_rem, r_quo[SUM_BITS-1]};
    assign w_diff     = w_shift - {1'b0, r_div};
    assign w_ge       = w_shift >= {1'b0, r_div};
    assign w_load_out = r_busy && r_done && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && !r_busy) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy && !r_done && r_step == STEP_BITS'(SUM_BITS - 1)) begin
                r_done <= 1'b1;
            end else if (w_load_out) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !r_busy) begin
            r_quo  <= i_sum;
            r_rem  <= '0;
            r_div  <= i_cnt;
            r_fin  <= i_fin;
            r_step <= '0;
        end else if (r_busy && !r_done) begin
            r_rem  <= w_ge ? w_diff[CNT_BITS-1:0] : w_shift[CNT_BITS-1:0];
            r_quo  <= {r_quo[SUM_BITS-2:0], w_ge};
            r_step <= r_step + STEP_BITS'(1);
        end
        if (w_load_out) begin
            r_avg     <= r_quo[AVG_BITS-1:0];
            r_out_fin <= r_fin;
        end
    end

    assign o_ready   = !r_busy;
    assign o_valid   = r_out_valid;
    assign o_average = r_avg;
    assign o_fin     = r_out_fin;

endmodule
